// ----- design/rrps_pkg.sv -----
// Package for the round-robin process scheduler: sizes, table entry type
// and the control/status structs passed between the top level and its memories.
// No dependencies.
`timescale 1ns / 1ps

package rrps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int ID_W      = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TIME_W    = 16;
    localparam int TICK_W    = 8;

    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // One process table entry.
    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [TICK_W-1:0] served;
        logic [TICK_W-1:0] required;
    } entry_t;

    // Process table port controls.
    typedef struct packed {
        logic            rd_en;
        logic [ID_W-1:0] rd_addr;
        logic            wr_en;
        logic [ID_W-1:0] wr_addr;
        entry_t          wr_data;
    } tbl_ctrl_t;

    // Ready FIFO controls: read the head, pop it, push an id.
    typedef struct packed {
        logic            rd_en;
        logic            pop;
        logic            push;
        logic [ID_W-1:0] push_id;
    } fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

// ----- design/rrps_proc_table.sv -----
// Per-process table: required ticks, served ticks, arrival stamp.
// Synchronous memory, one read and one write port, registered read data.
// Depends on rrps_pkg.
`timescale 1ns / 1ps

module rrps_proc_table
    import rrps_pkg::*;
(
    input  logic      clk,
    input  tbl_ctrl_t ctrl,
    output entry_t    rd_data
);

    entry_t mem [MAX_PROCS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        // read data holds between reads
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/rrps_ready_fifo.sv -----
// Ready queue of process ids: circular buffer in a synchronous memory
// with head/tail pointers and a fill count. Depends on rrps_pkg.
`timescale 1ns / 1ps

module rrps_ready_fifo
    import rrps_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  fifo_ctrl_t      ctrl,
    output logic [ID_W-1:0] head_id,
    output fifo_stat_t      stat
);

    logic [ID_W-1:0]  mem [MAX_PROCS];
    logic [ID_W-1:0]  head_id_reg;
    logic [ID_W-1:0]  head_reg, head_next;
    logic [ID_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // head id read is registered; pop only moves the pointer
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= ctrl.push_id;
        end
        if (ctrl.rd_en)
        begin
            head_id_reg <= mem[head_reg];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next = (head_reg == ID_W'(MAX_PROCS - 1)) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push)
        begin
            tail_next = (tail_reg == ID_W'(MAX_PROCS - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign head_id    = head_id_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(MAX_PROCS));

endmodule

// ----- design/round_robin_process_scheduler.sv -----
// Round-robin process scheduler, quantum of one tick.
// Arrival request: taken in IDLE, writes the process table and the ready FIFO.
// Tick request: states IDLE (table/FIFO read), DECIDE (decide, second dependent table
// read) and SERVE (served-count write-back, result registered); the next request is
// taken back in IDLE, later while an older result is held.
// rst_n (async, active low) empties the FIFO, idles the processor, zeroes time.
`timescale 1ns / 1ps

module round_robin_process_scheduler
    import rrps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] proc_id, [11:4] need_time, [15:12] zero
    input  logic        s_tuser,   // kind: 0 arrival, 1 tick
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [0] run_valid, [4:1] run_id, [5] done_valid,
                                   // [9:6] done_id, [25:10] finish_time,
                                   // [41:26] turnaround, [47:42] zero
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SERVE
    } state_t;

    state_t            state_reg, state_next;
    logic [ID_W-1:0]   run_id_reg, run_id_next;
    logic              run_valid_reg, run_valid_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              done_valid_reg, done_valid_next;
    logic [ID_W-1:0]   done_id_reg, done_id_next;
    logic [TIME_W-1:0] fin_reg, fin_next;
    logic [TIME_W-1:0] turn_reg, turn_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [47:0]       m_tdata_reg, m_tdata_next;

    tbl_ctrl_t         tbl_ctrl;
    entry_t            tbl_rd;
    fifo_ctrl_t        fifo_ctrl;
    fifo_stat_t        fifo_stat;
    logic [ID_W-1:0]   fifo_head_id;

    logic              in_fire;
    logic              out_free;
    logic [3:0]        in_pid;
    logic [7:0]        in_need;
    logic              pid_ok;
    logic              met;

    rrps_proc_table u_table (
        .clk     (clk),
        .ctrl    (tbl_ctrl),
        .rd_data (tbl_rd)
    );

    rrps_ready_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (fifo_ctrl),
        .head_id (fifo_head_id),
        .stat    (fifo_stat)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_pid   = s_tdata[3:0];
    assign in_need  = s_tdata[11:4];
    assign pid_ok   = (32'(in_pid) < MAX_PROCS);
    // running process has had its required service
    assign met      = run_valid_reg && (tbl_rd.served >= tbl_rd.required);

    always_comb
    begin
        state_next      = state_reg;
        run_id_next     = run_id_reg;
        run_valid_next  = run_valid_reg;
        now_next        = now_reg;
        done_valid_next = done_valid_reg;
        done_id_next    = done_id_reg;
        fin_next        = fin_reg;
        turn_next       = turn_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        tbl_ctrl        = '0;
        fifo_ctrl       = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser == KIND_ARRIVAL)
                    begin
                        // overwrite the entry, enqueue; dropped if FIFO full
                        if (pid_ok && !fifo_stat.full)
                        begin
                            tbl_ctrl.wr_en            = 1'b1;
                            tbl_ctrl.wr_addr          = in_pid[ID_W-1:0];
                            tbl_ctrl.wr_data.stamp    = now_reg;
                            tbl_ctrl.wr_data.served   = '0;
                            tbl_ctrl.wr_data.required = in_need;
                            fifo_ctrl.push            = 1'b1;
                            fifo_ctrl.push_id         = in_pid[ID_W-1:0];
                        end
                    end
                    else
                    begin
                        // fetch running entry and FIFO head
                        tbl_ctrl.rd_en   = 1'b1;
                        tbl_ctrl.rd_addr = run_id_reg;
                        fifo_ctrl.rd_en  = 1'b1;
                        state_next       = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                done_valid_next = met;
                done_id_next    = met ? run_id_reg : '0;
                fin_next        = met ? now_reg : '0;
                turn_next       = met ? (now_reg - tbl_rd.stamp) : '0;
                // head always leaves a non-empty FIFO; preempted process
                // goes behind it (pop before push, so it always fits)
                fifo_ctrl.pop     = !fifo_stat.empty;
                fifo_ctrl.push    = run_valid_reg && !met && !fifo_stat.empty;
                fifo_ctrl.push_id = run_id_reg;
                if (!fifo_stat.empty)
                begin
                    run_id_next    = fifo_head_id;
                    run_valid_next = 1'b1;
                end
                else if (met)
                begin
                    run_valid_next = 1'b0;
                end
                // fetch the entry to be served this slice
                tbl_ctrl.rd_en   = 1'b1;
                tbl_ctrl.rd_addr = run_id_next;
                now_next         = now_reg + 1'b1;
                state_next       = S_SERVE;
            end

            S_SERVE:
            begin
                if (out_free)
                begin
                    if (run_valid_reg)
                    begin
                        tbl_ctrl.wr_en   = 1'b1;
                        tbl_ctrl.wr_addr = run_id_reg;
                        tbl_ctrl.wr_data = tbl_rd;
                        if (tbl_rd.served != TICK_MAX)
                        begin
                            tbl_ctrl.wr_data.served = tbl_rd.served + 1'b1;
                        end
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, turn_reg, fin_reg, done_id_reg, done_valid_reg,
                                     run_valid_reg ? run_id_reg : ID_W'(0), run_valid_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            run_id_reg     <= '0;
            run_valid_reg  <= 1'b0;
            now_reg        <= '0;
            done_valid_reg <= 1'b0;
            done_id_reg    <= '0;
            fin_reg        <= '0;
            turn_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            run_id_reg     <= run_id_next;
            run_valid_reg  <= run_valid_next;
            now_reg        <= now_next;
            done_valid_reg <= done_valid_next;
            done_id_reg    <= done_id_next;
            fin_reg        <= fin_next;
            turn_reg       <= turn_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
